// File: rtl/rqdp_pkg.sv
// Shared types and constants for the ring queue with drop policy.
package rqdp_pkg;

   localparam int ITEM_W      = 32;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 5;
   localparam int DROP_W      = 32;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_IDX_W   = 1;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int ITEM_BITS_DEFAULT = 32;

   localparam logic [CSR_DATA_W-1:0] CAP_RESET = 5'd16;
   localparam logic [DROP_W-1:0]     DROP_MAX  = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLOSE = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_CLOSED = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 1'd0,
      CSR_POLICY   = 1'd1
   } csr_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

// File: rtl/rqdp_channels.sv
// Valid/ready channel interfaces for requests and responses.
interface rqdp_req_if import rqdp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ITEM_W-1:0] item_in;

   modport source (output valid, output func, output item_in, input ready);
   modport sink   (input valid, input func, input item_in, output ready);
endinterface

interface rqdp_rsp_if import rqdp_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [ITEM_W-1:0] item_out;
   logic              evicted_valid;
   logic [ITEM_W-1:0] evicted_item;
   logic [FILL_W-1:0] fill_count;
   logic [DROP_W-1:0] drop_count;
   logic              is_closed;

   modport source (output valid, output status, output item_out, output evicted_valid,
                   output evicted_item, output fill_count, output drop_count,
                   output is_closed, input ready);
   modport sink   (input valid, input status, input item_out, input evicted_valid,
                   input evicted_item, input fill_count, input drop_count,
                   input is_closed, output ready);
endinterface

// File: rtl/rqdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rqdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ring_queue_drop_policy_unit.sv
// Ring queue of item handles with reject or drop-oldest behavior when full.
// Push, close, and any operation that reports without reading a slot (push
// when closed, rejected push, pop of an empty queue) load the output register
// from ST_IDLE; a pop that returns an item and a drop-oldest push pass through
// ST_READ, since the head slot is read from the single-port-read slot RAM with
// registered read data, and the evicting push writes its new item in ST_READ.
// The result sits in an output register, so the next request is taken in the
// cycle its slot frees up. Slots are addressed modulo DEPTH; the capacity CSR
// only sets when the queue counts as full (0 acts as 1, above DEPTH acts as DEPTH).
module ring_queue_drop_policy_unit import rqdp_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   rqdp_req_if.sink              req,
   rqdp_rsp_if.source            rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int HW = $clog2(DEPTH + 1);
   localparam int CW = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;
   localparam int SW = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [HW-1:0]     held_ff, held_in;
   logic [DROP_W-1:0] drops_ff, drops_in;
   logic              closed_ff, closed_in;
   logic [CSR_DATA_W-1:0] cap_ff;
   logic              policy_ff;

   logic              pend_evict_ff, pend_evict_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [SW-1:0]     wr_item_ff, wr_item_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [ITEM_W-1:0] item_out_ff, item_out_in;
   logic              ev_valid_ff, ev_valid_in;
   logic [ITEM_W-1:0] ev_item_ff, ev_item_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [DROP_W-1:0] drop_out_ff, drop_out_in;
   logic              closed_out_ff, closed_out_in;

   logic              accept;
   logic              full;
   logic [CW-1:0]     cap_wide, cap_eff;
   logic [AW:0]       tail_sum;
   logic [AW-1:0]     tail;
   logic [AW-1:0]     head_next;
   logic [DROP_W-1:0] drops_inc;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [SW-1:0]     ram_wr_data;
   logic [SW-1:0]     ram_rd_data;
   logic [ITEM_W-1:0] rd_item;

   rqdp_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   always_comb begin
      cap_wide = CW'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = CW'(1);
      end else if (cap_wide > CW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
      full = CW'(held_ff) >= cap_eff;

      tail_sum = {1'b0, head_ff} + (AW + 1)'(held_ff);
      if (tail_sum >= (AW + 1)'(DEPTH)) begin
         tail = AW'(tail_sum - (AW + 1)'(DEPTH));
      end else begin
         tail = AW'(tail_sum);
      end

      head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      drops_inc = (drops_ff == DROP_MAX) ? drops_ff : drops_ff + DROP_W'(1);

      rd_item = '0;
      rd_item[SW-1:0] = ram_rd_data;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      held_in       = held_ff;
      drops_in      = drops_ff;
      closed_in     = closed_ff;
      pend_evict_in = pend_evict_ff;
      wr_addr_in    = wr_addr_ff;
      wr_item_in    = wr_item_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail;
      ram_wr_data   = req.item_in[SW-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      status_in     = status_ff;
      item_out_in   = item_out_ff;
      ev_valid_in   = ev_valid_ff;
      ev_item_in    = ev_item_ff;
      fill_in       = fill_ff;
      drop_out_in   = drop_out_ff;
      closed_out_in = closed_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               case (func_type'(req.func))
                  FUNC_PUSH: begin
                     if (closed_ff) begin
                        status_in = STAT_CLOSED;
                     end else if (full) begin
                        drops_in = drops_inc;
                        if (!policy_ff) begin
                           status_in = STAT_FULL;
                        end else begin
                           head_in       = head_next;
                           pend_evict_in = 1'b1;
                           wr_addr_in    = tail;
                           wr_item_in    = req.item_in[SW-1:0];
                           state_in      = ST_READ;
                        end
                     end else begin
                        ram_wr_en = 1'b1;
                        held_in   = held_ff + HW'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (held_ff == '0) begin
                        status_in = closed_ff ? STAT_CLOSED : STAT_EMPTY;
                     end else begin
                        head_in       = head_next;
                        held_in       = held_ff - HW'(1);
                        pend_evict_in = 1'b0;
                        state_in      = ST_READ;
                     end
                  end
                  FUNC_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_valid_in  = 1'b1;
                  item_out_in   = '0;
                  ev_valid_in   = 1'b0;
                  ev_item_in    = '0;
                  fill_in       = FILL_W'(held_in);
                  drop_out_in   = drops_in;
                  closed_out_in = closed_in;
               end
            end
         end
         ST_READ: begin
            ram_wr_en     = pend_evict_ff;
            ram_wr_addr   = wr_addr_ff;
            ram_wr_data   = wr_item_ff;
            rsp_valid_in  = 1'b1;
            status_in     = STAT_OK;
            item_out_in   = pend_evict_ff ? '0 : rd_item;
            ev_valid_in   = pend_evict_ff;
            ev_item_in    = pend_evict_ff ? rd_item : '0;
            fill_in       = FILL_W'(held_ff);
            drop_out_in   = drops_ff;
            closed_out_in = closed_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         held_ff       <= '0;
         drops_ff      <= '0;
         closed_ff     <= 1'b0;
         pend_evict_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         held_ff       <= held_in;
         drops_ff      <= drops_in;
         closed_ff     <= closed_in;
         pend_evict_ff <= pend_evict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         policy_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CAPACITY: cap_ff    <= csr_wr_data;
            CSR_POLICY:   policy_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      wr_item_ff    <= wr_item_in;
      status_ff     <= status_in;
      item_out_ff   <= item_out_in;
      ev_valid_ff   <= ev_valid_in;
      ev_item_ff    <= ev_item_in;
      fill_ff       <= fill_in;
      drop_out_ff   <= drop_out_in;
      closed_out_ff <= closed_out_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.item_out      = item_out_ff;
   assign rsp.evicted_valid = ev_valid_ff;
   assign rsp.evicted_item  = ev_item_ff;
   assign rsp.fill_count    = fill_ff;
   assign rsp.drop_count    = drop_out_ff;
   assign rsp.is_closed     = closed_out_ff;

endmodule

// File: verif/tb_ring_queue_drop_policy_unit.sv
// Self-checking testbench for the ring queue with reject or drop-oldest full policy.
`timescale 1ns / 1ps

module tb_ring_queue_drop_policy_unit;
   import rqdp_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
   localparam int RING_SLOTS  = 16;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      status_type        status;
      logic [ITEM_W-1:0] item_out;
      logic              evicted_valid;
      logic [ITEM_W-1:0] evicted_item;
      logic [FILL_W-1:0] fill_count;
      logic [DROP_W-1:0] drop_count;
      logic              is_closed;
   } queue_reply_type;

   typedef struct {
      logic              is_csr;
      csr_idx_type       csr_idx;
      logic [4:0]        csr_data;
      logic [FUNC_W-1:0] func;
      logic [ITEM_W-1:0] item;
      logic              has_reply;
      queue_reply_type   reply;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   rqdp_req_if req_ch ();
   rqdp_rsp_if rsp_ch ();

   ring_queue_drop_policy_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source)
   );

   // shadow of the queue
   logic [ITEM_W-1:0] ring_slots [RING_SLOTS];
   logic [3:0]        ring_head;
   logic [4:0]        ring_fill;
   logic [DROP_W-1:0] ring_drops;
   logic              ring_closed;
   logic [4:0]        cfg_capacity;
   logic              cfg_evict;

   queue_reply_type replies_owed [$];
   plan_row_type    plan [$];
   queue_reply_type row_reply;
   logic            row_has_reply;

   int error_count;
   int idle_cycles = 0;
   int send_idle_pct;
   int recv_stall_pct;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic queue_reply_type apply_queue_op(logic [FUNC_W-1:0] f,
                                                      logic [ITEM_W-1:0] v);
      queue_reply_type r;
      logic [4:0]      limit;
      r = '0;
      limit = (cfg_capacity == 5'd0) ? 5'd1 :
              (cfg_capacity > 5'(RING_SLOTS)) ? 5'(RING_SLOTS) : cfg_capacity;
      case (f)
         FUNC_PUSH: begin
            if (ring_closed) begin
               r.status = STAT_CLOSED;
            end else if (ring_fill >= limit) begin
               if (ring_drops != DROP_MAX) ring_drops = ring_drops + 1'b1;
               if (!cfg_evict) begin
                  r.status = STAT_FULL;
               end else begin
                  r.evicted_valid = 1'b1;
                  r.evicted_item  = ring_slots[ring_head];
                  ring_slots[4'(ring_head + ring_fill)] = v;
                  ring_head = ring_head + 1'b1;
               end
            end else begin
               ring_slots[4'(ring_head + ring_fill)] = v;
               ring_fill = ring_fill + 1'b1;
            end
         end
         FUNC_POP: begin
            if (ring_fill == 5'd0) begin
               r.status = ring_closed ? STAT_CLOSED : STAT_EMPTY;
            end else begin
               r.item_out = ring_slots[ring_head];
               ring_head  = ring_head + 1'b1;
               ring_fill  = ring_fill - 1'b1;
            end
         end
         FUNC_CLOSE: ring_closed = 1'b1;
         default: ;
      endcase
      r.fill_count = ring_fill;
      r.drop_count = ring_drops;
      r.is_closed  = ring_closed;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
   endtask

   // transfer bookkeeping and response checks
   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = apply_queue_op(req_ch.func, req_ch.item_in);
            if (row_has_reply) want = row_reply;
            replies_owed.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_owed.size() == 0) begin
               error_count++;
               $display("%0t ns: response transfer with nothing outstanding", $time);
            end else begin
               want = replies_owed.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("item_out", want.item_out, rsp_ch.item_out);
               check_field("evicted_valid", want.evicted_valid, rsp_ch.evicted_valid);
               check_field("evicted_item", want.evicted_item, rsp_ch.evicted_item);
               check_field("fill_count", want.fill_count, rsp_ch.fill_count);
               check_field("drop_count", want.drop_count, rsp_ch.drop_count);
               check_field("is_closed", want.is_closed, rsp_ch.is_closed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   function automatic void plan_op(logic [FUNC_W-1:0] f, logic [ITEM_W-1:0] v);
      plan_row_type row;
      row = '{is_csr: 1'b0, csr_idx: CSR_CAPACITY, csr_data: '0, func: f, item: v,
              has_reply: 1'b0, reply: '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_checked(logic [FUNC_W-1:0] f, logic [ITEM_W-1:0] v,
                                        status_type st, logic [ITEM_W-1:0] out,
                                        logic evv, logic [ITEM_W-1:0] evi,
                                        logic [FILL_W-1:0] fill, logic [DROP_W-1:0] drops);
      plan_row_type row;
      row = '{is_csr: 1'b0, csr_idx: CSR_CAPACITY, csr_data: '0, func: f, item: v,
              has_reply: 1'b1, reply: '0};
      row.reply = '{status: st, item_out: out, evicted_valid: evv, evicted_item: evi,
                    fill_count: fill, drop_count: drops, is_closed: 1'b0};
      plan.push_back(row);
   endfunction

   function automatic void plan_csr(csr_idx_type idx, logic [4:0] data);
      plan_row_type row;
      row = '{is_csr: 1'b1, csr_idx: idx, csr_data: data, func: FUNC_NOP, item: '0,
              has_reply: 1'b0, reply: '0};
      plan.push_back(row);
   endfunction

   task automatic send_op(logic [FUNC_W-1:0] f, logic [ITEM_W-1:0] v,
                          logic has_reply, queue_reply_type reply);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.item_in <= v;
      row_has_reply  <= has_reply;
      row_reply      <= reply;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender off until every outstanding response is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (replies_owed.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [4:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CAPACITY) cfg_capacity = data;
      else cfg_evict = data[0];
   endtask

   task automatic walk_plan();
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].csr_idx, plan[i].csr_data);
         end else begin
            send_op(plan[i].func, plan[i].item, plan[i].has_reply, plan[i].reply);
         end
      end
      plan.delete();
   endtask

   task automatic run_random(int count, bit allow_close);
      int                push_pct;
      int                roll;
      logic [FUNC_W-1:0] f;
      logic [ITEM_W-1:0] v;
      push_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) push_pct = 20 + 30 * $urandom_range(2);
         roll = $urandom_range(99);
         if (roll < 3) f = FUNC_NOP;
         else if (roll < 6 && allow_close) f = FUNC_CLOSE;
         else if ($urandom_range(99) < push_pct) f = FUNC_PUSH;
         else f = FUNC_POP;
         case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            default: v = $urandom();
         endcase
         send_op(f, v, 1'b0, '0);
      end
   endtask

   initial begin
      logic [4:0] cap;
      logic       evict;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_CAPACITY;
      csr_wr_data    <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_PUSH;
      req_ch.item_in <= '0;
      row_has_reply  <= 1'b0;
      row_reply      <= '0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (ring_slots[i]) ring_slots[i] = '0;
      ring_head    = '0;
      ring_fill    = '0;
      ring_drops   = '0;
      ring_closed  = 1'b0;
      cfg_capacity = CAP_RESET;
      cfg_evict    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, extreme handles, full and evict paths, odd capacities
      plan_checked(FUNC_POP,  32'h0,        STAT_EMPTY, 32'h0, 1'b0, 32'h0, 5'd0, 32'd0);
      plan_checked(FUNC_PUSH, 32'h0,        STAT_OK,    32'h0, 1'b0, 32'h0, 5'd1, 32'd0);
      plan_checked(FUNC_PUSH, 32'hFFFFFFFF, STAT_OK,    32'h0, 1'b0, 32'h0, 5'd2, 32'd0);
      plan_checked(FUNC_POP,  32'h0,        STAT_OK,    32'h0, 1'b0, 32'h0, 5'd1, 32'd0);
      plan_checked(FUNC_POP,  32'h0,        STAT_OK,    32'hFFFFFFFF, 1'b0, 32'h0, 5'd0,
                   32'd0);
      plan_checked(FUNC_NOP,  32'hA5A5A5A5, STAT_OK,    32'h0, 1'b0, 32'h0, 5'd0, 32'd0);
      plan_csr(CSR_CAPACITY, 5'd1);
      plan_checked(FUNC_PUSH, 32'h12345678, STAT_OK,    32'h0, 1'b0, 32'h0, 5'd1, 32'd0);
      plan_checked(FUNC_PUSH, 32'h9ABCDEF0, STAT_FULL,  32'h0, 1'b0, 32'h0, 5'd1, 32'd1);
      plan_csr(CSR_POLICY, 5'b11111);
      plan_checked(FUNC_PUSH, 32'h0F0F0F0F, STAT_OK,    32'h0, 1'b1, 32'h12345678, 5'd1,
                   32'd2);
      plan_checked(FUNC_POP,  32'h0,        STAT_OK,    32'h0F0F0F0F, 1'b0, 32'h0, 5'd1 - 5'd1,
                   32'd2);
      plan_csr(CSR_CAPACITY, 5'd0);
      plan_op(FUNC_PUSH, 32'hDEADBEEF);
      plan_op(FUNC_PUSH, 32'h00000001);
      plan_csr(CSR_CAPACITY, 5'd31);
      plan_op(FUNC_PUSH, 32'h80000000);
      plan_op(FUNC_PUSH, 32'h7FFFFFFF);
      plan_op(FUNC_PUSH, 32'h2468ACE0);
      plan_csr(CSR_CAPACITY, 5'd1);
      plan_op(FUNC_PUSH, 32'h55555555);
      plan_csr(CSR_POLICY, 5'd0);
      plan_op(FUNC_PUSH, 32'hAAAAAAAA);
      plan_op(FUNC_POP, 32'h0);
      plan_op(FUNC_POP, 32'h0);
      plan_op(FUNC_POP, 32'h0);
      plan_op(FUNC_PUSH, 32'h13579BDF);
      plan_op(FUNC_POP, 32'h0);
      plan_op(FUNC_POP, 32'h0);
      walk_plan();

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: begin cap = 5'd16; evict = 1'b0; end
            1: begin cap = 5'd4;  evict = 1'b1; end
            2: begin cap = 5'd0;  evict = 1'b0; end
            3: begin cap = 5'd31; evict = 1'b1; end
            4: begin cap = 5'($urandom_range(1, 16)); evict = 1'b0; end
            5: begin cap = 5'd2;  evict = 1'b1; end
            6: begin cap = 5'd16; evict = 1'b1; end
            default: begin cap = 5'($urandom_range(31)); evict = 1'($urandom_range(1)); end
         endcase
         write_csr(CSR_CAPACITY, cap);
         write_csr(CSR_POLICY, {4'($urandom_range(15)), evict});
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         run_random(185, 1'b0);
      end

      // closing: refused pushes, repeated close, drain, then pops on a closed empty queue
      settle();
      plan_op(FUNC_CLOSE, 32'h0);
      plan_op(FUNC_PUSH, 32'hC0FFEE00);
      plan_op(FUNC_CLOSE, 32'hFFFFFFFF);
      for (int k = 0; k < RING_SLOTS + 2; k++) plan_op(FUNC_POP, 32'h0);
      walk_plan();
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      run_random(120, 1'b1);

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && replies_owed.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
